// ----- hw/rtl/csrmm_pkg.sv -----
// Shared types and constants for the CSR sparse times dense matrix product core.
// Holds the transfer payload structs, opcodes and register indexes.
// No dependencies; every other file of the core but csrmm_ram imports it.
package csrmm_pkg;

  localparam int MAX_K_DEF       = 1024;
  localparam int MAX_COLS_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Field widths fixed by the interface.
  localparam int NCOLS_W = 7;
  localparam int KIDX_W  = 10;
  localparam int CIDX_W  = 6;
  localparam int ROW_W   = 16;
  localparam int SUM_W   = 64;
  localparam int DATA_W  = 32;
  localparam int KEXT_W  = 17;
  localparam int ADDR_W  = 3;

  localparam logic [0:0] REG_N_COLS = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NZ    = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [KIDX_W-1:0]  k_index;
    logic [CIDX_W-1:0]  col_index;
    logic signed [31:0] value;
    logic               last_in_row;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic [CIDX_W-1:0]       col;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } out_item_t;

endpackage

// ----- hw/rtl/csrmm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the dense matrix store and the row accumulator.
// No package dependencies.
module csrmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/csr_sparse_dense_matmul_core.sv -----
// Top level of the CSR sparse times dense matrix product core.
// Depends on csrmm_pkg and on csrmm_ram for the dense store and the row accumulator.
//
//   channel | ports                                   | moves
//   in      | in_valid, in_ready, in_data             | C load, B nonzero or empty row
//   out     | out_valid, out_ready, out_data          | one A element per transfer
//   cfg     | psel, penable, pwrite, paddr, pwdata,   | n_cols register
//           | prdata, pready                          |
//
// A load or an ignored item is taken without leaving idle. A B nonzero does one dense store read
// and one multiply per active column, then drains the multiply and accumulate stages.
// Emitting a row keeps a single accumulator read outstanding, which feeds the output register,
// so the next column is read only after the previous read has returned.
// Reset is synchronous; accumulator entries carry valid bits, so there is no clearing pass.
// While out_ready is low, emission holds and no new item is taken until the last column
// of the row has been read from the accumulator.
module csr_sparse_dense_matmul_core #(
  parameter int MAX_K       = csrmm_pkg::MAX_K_DEF,
  parameter int MAX_COLS    = csrmm_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = csrmm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  csrmm_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output csrmm_pkg::out_item_t         out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csrmm_pkg::ADDR_W-1:0] paddr,
  input  logic [csrmm_pkg::DATA_W-1:0] pwdata,
  output logic [csrmm_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  import csrmm_pkg::*;

  localparam int KW       = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DS_DEPTH = (2 ** KW) * (2 ** CW);
  localparam int AC_DEPTH = 2 ** CW;
  localparam int PROD_W   = 2 * VALUE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [NCOLS_W-1:0]             n_cols_r, n_cols_nxt;
  logic [ROW_W-1:0]               row_r, row_nxt;
  logic [CW-1:0]                  j_r, j_nxt;
  logic [KW-1:0]                  k_r, k_nxt;
  logic signed [VALUE_WIDTH-1:0]  b_val_r, b_val_nxt;
  logic                           last_r, last_nxt;
  logic [MAX_COLS-1:0]            acc_vld_r, acc_vld_nxt;

  logic                           s1_vld_r, s1_vld_nxt;
  logic [CW-1:0]                  s1_col_r, s1_col_nxt;
  logic                           s2_vld_r, s2_vld_nxt;
  logic [CW-1:0]                  s2_col_r, s2_col_nxt;
  logic                           s2_hit_r, s2_hit_nxt;
  logic signed [SUM_W-1:0]        prod_r, prod_nxt;

  logic                           rd_pend_r, rd_pend_nxt;
  logic                           pend_hit_r, pend_hit_nxt;
  logic [CIDX_W-1:0]              pend_col_r, pend_col_nxt;
  logic                           pend_last_r, pend_last_nxt;
  logic [ROW_W-1:0]               pend_row_r, pend_row_nxt;

  logic                           out_valid_r, out_valid_nxt;
  out_item_t                      out_data_r, out_data_nxt;

  logic [NCOLS_W-1:0]             act_cols;
  logic                           col_is_last;
  logic                           in_fire;
  logic [KEXT_W-1:0]              k_ext;
  logic                           k_ok;
  logic                           c_ok;
  logic                           cfg_wr;
  logic                           emit_issue;

  logic                           ds_we;
  logic [KW+CW-1:0]               ds_waddr;
  logic [KW+CW-1:0]               ds_raddr;
  logic [VALUE_WIDTH-1:0]         ds_rdata;
  logic                           ac_we;
  logic [CW-1:0]                  ac_raddr;
  logic [SUM_W-1:0]               ac_wdata;
  logic [SUM_W-1:0]               ac_rdata;
  logic signed [PROD_W-1:0]       mul_w;

  // Column count in use: zero acts as one, values above the store width clamp.
  always_comb begin
    if (n_cols_r == '0) begin
      act_cols = NCOLS_W'(1);
    end else if (n_cols_r > NCOLS_W'(MAX_COLS)) begin
      act_cols = NCOLS_W'(MAX_COLS);
    end else begin
      act_cols = n_cols_r;
    end
  end

  assign col_is_last = (NCOLS_W'(j_r) == act_cols - NCOLS_W'(1));
  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign k_ext       = KEXT_W'(in_data.k_index);
  assign k_ok        = (k_ext < KEXT_W'(MAX_K));
  assign c_ok        = (NCOLS_W'(in_data.col_index) < NCOLS_W'(MAX_COLS));

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_N_COLS) ? DATA_W'(n_cols_r) : '0;
  assign n_cols_nxt = (cfg_wr && (paddr[2] == REG_N_COLS)) ? pwdata[NCOLS_W-1:0] : n_cols_r;

  // Dense store: loads write directly, the nonzero sweep reads one column per cycle.
  assign ds_we    = in_fire && (in_data.op == OP_LOAD) && k_ok && c_ok;
  assign ds_waddr = {k_ext[KW-1:0], in_data.col_index[CW-1:0]};
  assign ds_raddr = {k_r, j_r};

  csrmm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DS_DEPTH)
  ) u_dense (
    .clk   (clk),
    .we    (ds_we),
    .waddr (ds_waddr),
    .wdata (in_data.value[VALUE_WIDTH-1:0]),
    .raddr (ds_raddr),
    .rdata (ds_rdata)
  );

  // Accumulator: read at stage one or during emission, written back at stage two.
  assign emit_issue = (state_r == S_EMIT) && !rd_pend_r && (!out_valid_r || out_ready);
  assign ac_raddr   = (state_r == S_EMIT) ? j_r : s1_col_r;
  assign ac_we      = s2_vld_r;
  assign ac_wdata   = (s2_hit_r ? ac_rdata : '0) + prod_r;

  csrmm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (AC_DEPTH)
  ) u_acc (
    .clk   (clk),
    .we    (ac_we),
    .waddr (s2_col_r),
    .wdata (ac_wdata),
    .raddr (ac_raddr),
    .rdata (ac_rdata)
  );

  assign mul_w    = b_val_r * $signed(ds_rdata);
  assign prod_nxt = SUM_W'(mul_w);

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    b_val_nxt   = b_val_r;
    last_nxt    = last_r;
    acc_vld_nxt = acc_vld_r;
    s1_vld_nxt  = 1'b0;
    s1_col_nxt  = j_r;
    s2_vld_nxt  = s1_vld_r;
    s2_col_nxt  = s1_col_r;
    s2_hit_nxt  = acc_vld_r[s1_col_r];

    rd_pend_nxt   = emit_issue;
    pend_hit_nxt  = acc_vld_r[j_r];
    pend_col_nxt  = CIDX_W'(j_r);
    pend_last_nxt = col_is_last;
    pend_row_nxt  = row_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (s2_vld_r) begin
      acc_vld_nxt[s2_col_r] = 1'b1;
    end

    if (rd_pend_r) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.row_index = pend_row_r;
      out_data_nxt.col       = pend_col_r;
      out_data_nxt.sum       = pend_hit_r ? $signed(ac_rdata) : '0;
      out_data_nxt.last      = pend_last_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          j_nxt     = '0;
          k_nxt     = k_ext[KW-1:0];
          b_val_nxt = $signed(in_data.value[VALUE_WIDTH-1:0]);
          last_nxt  = in_data.last_in_row;
          case (in_data.op)
            OP_NZ: begin
              if (k_ok) begin
                state_nxt = S_MAC;
              end else if (in_data.last_in_row) begin
                state_nxt = S_EMIT;
              end
            end
            OP_EMPTY: state_nxt = S_EMIT;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_MAC: begin
        s1_vld_nxt = 1'b1;
        j_nxt      = j_r + CW'(1);
        if (col_is_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Stage two may still write this cycle; the next read sees it.
        if (!s1_vld_r) begin
          j_nxt     = '0;
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_issue) begin
          j_nxt = j_r + CW'(1);
          if (col_is_last) begin
            acc_vld_nxt = '0;
            row_nxt     = row_r + ROW_W'(1);
            j_nxt       = '0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_cols_r    <= NCOLS_W'(MAX_COLS);
      row_r       <= '0;
      j_r         <= '0;
      acc_vld_r   <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_cols_r    <= n_cols_nxt;
      row_r       <= row_nxt;
      j_r         <= j_nxt;
      acc_vld_r   <= acc_vld_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    b_val_r     <= b_val_nxt;
    last_r      <= last_nxt;
    s1_col_r    <= s1_col_nxt;
    s2_col_r    <= s2_col_nxt;
    s2_hit_r    <= s2_hit_nxt;
    prod_r      <= prod_nxt;
    pend_hit_r  <= pend_hit_nxt;
    pend_col_r  <= pend_col_nxt;
    pend_last_r <= pend_last_nxt;
    pend_row_r  <= pend_row_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Emission reads the accumulator only after the multiply pipeline has drained.
  a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (!s1_vld_r && !s2_vld_r))
    else $error("accumulator emission overlaps the multiply pipeline");

  // A pending accumulator read always finds the output register free.
  a_pend_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("emission read returned while the output register was full");

  // The write-back stage only runs in the cycle after a stage-one read.
  a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> $past(s1_vld_r))
    else $error("accumulator write-back without a matching read");

  // The column counter stays below the active column count while sweeping.
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MAC) || (state_r == S_EMIT)) |-> (NCOLS_W'(j_r) < act_cols))
    else $error("column counter ran past the active column count");

endmodule

// ----- verif/csrmm_checker.sv -----
// Scoreboard for the CSR sparse times dense matrix product core: watches the input,
// result and register ports, predicts every A element and compares it field by field.
// Depends on csrmm_pkg for the payload structs, opcodes and register index.
module csrmm_checker #(
  parameter int MAX_K    = csrmm_pkg::MAX_K_DEF,
  parameter int MAX_COLS = csrmm_pkg::MAX_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  csrmm_pkg::in_item_t          in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  csrmm_pkg::out_item_t         out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csrmm_pkg::ADDR_W-1:0] paddr,
  input  logic [csrmm_pkg::DATA_W-1:0] pwdata,
  input  logic [csrmm_pkg::DATA_W-1:0] prdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending,
  output int                           results_seen
);
  import csrmm_pkg::*;

  localparam logic [ADDR_W-1:0] NCOLS_ADDR = ADDR_W'({REG_N_COLS, 2'b00});

  logic signed [DATA_W-1:0] c_store [MAX_K*MAX_COLS];
  logic [SUM_W-1:0]         row_acc [MAX_COLS];
  logic [ROW_W-1:0]         row_num;
  logic [NCOLS_W-1:0]       cols_reg;
  out_item_t                expected_elems [$];

  function automatic int active_cols(logic [NCOLS_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MAX_COLS) return MAX_COLS;
    return int'(r);
  endfunction

  task automatic emit_row_sums();
    int        n;
    out_item_t e;
    n = active_cols(cols_reg);
    for (int j = 0; j < n; j++) begin
      e.row_index = row_num;
      e.col       = CIDX_W'(j);
      e.sum       = row_acc[j];
      e.last      = (j == n - 1);
      expected_elems.push_back(e);
    end
    // Columns beyond the active count are cleared as well.
    for (int j = 0; j < MAX_COLS; j++) row_acc[j] = '0;
    row_num = row_num + 1'b1;
  endtask

  task automatic absorb_item(in_item_t it);
    longint b;
    longint p;
    int     n;
    int     k;
    k = int'(it.k_index);
    case (it.op)
      OP_LOAD: begin
        if (k < MAX_K && int'(it.col_index) < MAX_COLS)
          c_store[k*MAX_COLS + int'(it.col_index)] = it.value;
      end
      OP_NZ: begin
        if (k < MAX_K) begin
          n = active_cols(cols_reg);
          b = longint'($signed(it.value));
          for (int j = 0; j < n; j++) begin
            p = b * longint'(c_store[k*MAX_COLS + j]);
            row_acc[j] = row_acc[j] + p;
          end
        end
        if (it.last_in_row) emit_row_sums();
      end
      OP_EMPTY: emit_row_sums();
      default: ;
    endcase
  endtask

  task automatic compare_elem(out_item_t got);
    out_item_t want;
    if (expected_elems.size() == 0) begin
      $error("result transfer with nothing expected: row %0d col %0d sum %0d",
             got.row_index, got.col, $signed(got.sum));
      fail_count++;
      return;
    end
    want = expected_elems.pop_front();
    if (got.row_index !== want.row_index) begin
      $error("row_index mismatch: expected %0d, actual %0d", want.row_index, got.row_index);
      fail_count++;
    end
    if (got.col !== want.col) begin
      $error("col mismatch: expected %0d, actual %0d", want.col, got.col);
      fail_count++;
    end
    if (got.sum !== want.sum) begin
      $error("sum mismatch: expected %0d, actual %0d", $signed(want.sum), $signed(got.sum));
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_COLS; j++) row_acc[j] = '0;
      row_num = '0;
      cols_reg = NCOLS_W'(MAX_COLS);
      expected_elems.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (psel && penable && pready && paddr == NCOLS_ADDR) begin
        if (pwrite) begin
          cols_reg = pwdata[NCOLS_W-1:0];
        end else if (prdata[NCOLS_W-1:0] !== cols_reg) begin
          $error("n_cols readback mismatch: expected %0d, actual %0d",
                 cols_reg, prdata[NCOLS_W-1:0]);
          fail_count++;
        end
      end
      if (in_valid && in_ready) absorb_item(in_data);
      if (out_valid && out_ready) begin
        results_seen++;
        compare_elem(out_data);
      end
    end
    pending = expected_elems.size();
  end

endmodule

// ----- verif/tb.sv -----
// Top of the testbench for the CSR sparse times dense matrix product core: drives loads,
// nonzeros, empty rows, reserved opcodes and register writes with random idling, and gives the verdict.
// Depends on csrmm_pkg, the core itself and csrmm_checker.
module tb;
  import csrmm_pkg::*;

  localparam int MAX_K        = MAX_K_DEF;
  localparam int MAX_COLS     = MAX_COLS_DEF;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS = 140;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [1:0]        OP_RESERVED = 2'd3;
  localparam logic [ADDR_W-1:0] NCOLS_ADDR  = ADDR_W'({REG_N_COLS, 2'b00});
  localparam logic [ADDR_W-1:0] SPARE_ADDR  = '1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int  fail_count;
  int  pending;
  int  results_seen;
  bit  hold_req = 1'b0;
  bit  valid_on = 1'b0;
  int  burst_left = 0;
  int  items_sent = 0;
  int  cfg_writes = 0;
  int  n_eff = MAX_COLS;
  int  row_pool [$];
  bit [MAX_COLS-1:0] loaded_cols [MAX_K];

  csr_sparse_dense_matmul_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  csrmm_checker #(.MAX_K(MAX_K), .MAX_COLS(MAX_COLS)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 4000000);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: segments of steady, light or heavy stalling, plus one long hold-off on request.
  initial begin
    int mode;
    int seg;
    mode = 0;
    seg  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 2);
          seg  = $urandom_range(10, 80);
        end
        seg--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_item(op_t op, int k, int c, logic [31:0] v, logic last);
    in_item_t it;
    it.op          = op;
    it.k_index     = KIDX_W'(k);
    it.col_index   = CIDX_W'(c);
    it.value       = v;
    it.last_in_row = last;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  task automatic pause_input();
    if (valid_on) begin
      in_valid <= 1'b0;
      valid_on = 1'b0;
    end
  endtask

  // Called on a falling edge; returns on a falling edge after the transfer.
  task automatic send_item(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    valid_on = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause_input();
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
  endtask

  task automatic load_elem(int k, int c, logic [31:0] v);
    send_item(make_item(OP_LOAD, k, c, v, 1'($urandom_range(0, 1))));
    loaded_cols[k][c] = 1'b1;
  endtask

  task automatic send_nonzero(int k, logic [31:0] v, logic last);
    send_item(make_item(OP_NZ, k, $urandom_range(0, 63), v, last));
  endtask

  task automatic send_empty();
    send_item(make_item(OP_EMPTY, $urandom_range(0, 1023), $urandom_range(0, 63),
                        $urandom(), 1'($urandom_range(0, 1))));
  endtask

  task automatic wait_results_done();
    pause_input();
    while (pending != 0) @(negedge clk);
    // A nonzero without a row end may still be accumulating.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write then read back one register; called on a falling edge with the core idle.
  task automatic set_cols_reg(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    cfg_writes++;
    if (a == NCOLS_ADDR) begin
      if (d[NCOLS_W-1:0] == '0) n_eff = 1;
      else if (int'(d[NCOLS_W-1:0]) > MAX_COLS) n_eff = MAX_COLS;
      else n_eff = int'(d[NCOLS_W-1:0]);
    end
  endtask

  // Load every active column of the first rows of the pool that is still missing.
  task automatic prime_rows(int use_rows);
    int k;
    for (int i = 0; i < use_rows; i++) begin
      k = row_pool[i];
      for (int c = 0; c < n_eff; c++)
        if (!loaded_cols[k][c]) load_elem(k, c, rand_value());
    end
  endtask

  task automatic send_random_row(int use_rows);
    int kind;
    int nnz;
    bit close_empty;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      send_empty();
    end else if (kind == 1) begin
      if ($urandom_range(0, 1))
        send_item(make_item(op_t'(OP_RESERVED), $urandom_range(0, 1023),
                            $urandom_range(0, 63), $urandom(), 1'($urandom_range(0, 1))));
      else
        load_elem(row_pool[$urandom_range(0, use_rows - 1)], $urandom_range(0, n_eff - 1),
                  rand_value());
    end else begin
      nnz = $urandom_range(1, 4);
      close_empty = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < nnz; i++)
        send_nonzero(row_pool[$urandom_range(0, use_rows - 1)], rand_value(),
                     (i == nnz - 1) && !close_empty);
      if (close_empty) send_empty();
    end
  endtask

  initial begin
    int start_items;
    int phase;
    int setting;
    int big_phases;
    int use_rows;
    phase = 0;
    big_phases = 0;
    row_pool.push_back(0);
    row_pool.push_back(MAX_K - 1);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Empty row straight after reset, with a stray row mark.
    send_item(make_item(OP_EMPTY, 1023, 63, 32'hFFFF_FFFF, 1'b1));
    send_item(make_item(op_t'(OP_RESERVED), 1023, 63, 32'hFFFF_FFFF, 1'b1));
    load_elem(0, 0, 32'h7FFF_FFFF);
    load_elem(0, 1, 32'hFFFF_FFFF);
    load_elem(1023, 0, 32'h8000_0000);
    load_elem(1023, 1, 32'h1234_5678);
    load_elem(1023, 63, 32'h8000_0000);
    load_elem(0, 63, 32'h7FFF_FFFF);
    wait_results_done();
    set_cols_reg(NCOLS_ADDR, 32'd1);
    // Most negative squared twice adds 2^63; after the row 0 product the 64-bit sum stays in range.
    send_nonzero(0, 32'h8000_0000, 1'b0);
    send_nonzero(1023, 32'h8000_0000, 1'b0);
    send_nonzero(1023, 32'h8000_0000, 1'b1);
    send_nonzero(0, 32'd5, 1'b0);
    send_empty();
    wait_results_done();
    set_cols_reg(NCOLS_ADDR, 32'd0);
    send_nonzero(0, 32'h7FFF_FFFF, 1'b1);
    wait_results_done();
    set_cols_reg(NCOLS_ADDR, 32'd2);
    send_nonzero(1023, 32'hFFFF_FFF9, 1'b0);
    send_nonzero(0, 32'h8000_0000, 1'b0);
    // Column count shrinks in the middle of a row; column 1 must still be cleared.
    wait_results_done();
    set_cols_reg(NCOLS_ADDR, 32'd1);
    send_nonzero(0, 32'd3, 1'b1);
    wait_results_done();
    set_cols_reg(NCOLS_ADDR, 32'd2);
    send_empty();
    wait_results_done();
    set_cols_reg(SPARE_ADDR, 32'd5);
    set_cols_reg(NCOLS_ADDR, 32'hFFFF_FFFF);
    send_empty();

    // Random part: phases of well-formed rows over a primed pool of C rows.
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      wait_results_done();
      if (phase == 0) begin
        setting = MAX_COLS;
        big_phases++;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            if (big_phases < 2) begin
              setting = $urandom_range(0, 1) ? 100 : MAX_COLS;
              big_phases++;
            end else begin
              setting = 3;
            end
          end
          1: setting = 0;
          default: setting = $urandom_range(1, 8);
        endcase
      end
      set_cols_reg(NCOLS_ADDR, ($urandom() & ~32'h7F) | 32'(setting));
      if (row_pool.size() < 8 && $urandom_range(0, 1)) row_pool.push_back($urandom_range(1, 1022));
      use_rows = (n_eff > 8) ? 2 : row_pool.size();
      prime_rows(use_rows);
      // Full-width rows in the first phase fill the output side during the long hold-off.
      if (phase == 0) hold_req = 1'b1;
      repeat ($urandom_range(3, 8)) send_random_row(use_rows);
      phase++;
    end

    pause_input();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d input transfers, checked %0d result transfers, %0d register writes.",
             items_sent, results_seen, cfg_writes);
    $display("Column counts 0 to 127, mid-row count change and a long output hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- csr_sparse_dense_matmul_core.f -----
hw/rtl/csrmm_pkg.sv
hw/rtl/csrmm_ram.sv
hw/rtl/csr_sparse_dense_matmul_core.sv
verif/csrmm_checker.sv
verif/tb.sv
